### hdl/bfdo_pkg.sv
// Shared types and constants for the voice byte FIFO with sample reader.
package bfdo_pkg;

	localparam int BUFFER_BYTES     = 4096;
	localparam int ADDR_W           = $clog2(BUFFER_BYTES);
	localparam int FILL_W           = 13;
	localparam int MAX_READ_SAMPLES = 64;
	localparam int CNT_W            = 7;
	localparam int QDEPTH           = 4;
	localparam int QPTR_W           = $clog2(QDEPTH);
	localparam int QCNT_W           = QPTR_W + 1;

	localparam logic ACT_WRITE    = 1'b0;
	localparam logic ACT_READ     = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef enum logic [0:0] {
		CMD_WRITE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         data;
		logic [CNT_W-1:0]   count;
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} bfdo_state_t;

endpackage

### hdl/bfdo_front.sv
// Front stage: accept transfers, drop ignored items, saturate the sample count.
module bfdo_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [7:0]                 data_byte,
	input  logic                       frame_is_voice,
	input  logic                       frame_last,
	input  logic [bfdo_pkg::CNT_W-1:0] sample_count,
	output logic                       push_valid,
	output bfdo_pkg::cmd_t             push_cmd,
	input  logic                       q_full
);
	import bfdo_pkg::*;

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic             accept;
	logic             push;
	logic             keep;
	logic             frame_end;
	cmd_t             cmd_in;

	assign frame_end = frame_last;
	assign push      = valid_s1 && !q_full;
	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cmd_in.kind  = (action == ACT_READ) ? CMD_READ : CMD_WRITE;
		cmd_in.data  = data_byte;
		cmd_in.count = (sample_count > CNT_W'(MAX_READ_SAMPLES)) ?
			CNT_W'(MAX_READ_SAMPLES) : sample_count;
		if (action == ACT_READ) begin
			keep = (sample_count != '0);
		end else begin
			keep = frame_is_voice || (frame_end && 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

	assign push_valid = push;
	assign push_cmd   = cmd_s1;

endmodule

### hdl/bfdo_cmd_fifo.sv
// Short command queue between the front and back stages.
module bfdo_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  bfdo_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output bfdo_pkg::cmd_t pop_cmd
);
	import bfdo_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### hdl/bfdo_back.sv
// Back stage: byte store, pointers, read sequencer and output register.
module bfdo_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  bfdo_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [7:0]                  first_byte,
	output logic [7:0]                  second_byte,
	output logic                        last,
	output logic [bfdo_pkg::FILL_W-1:0] fill_level
);
	import bfdo_pkg::*;

	logic [7:0]        store [BUFFER_BYTES];
	bfdo_state_t       state_q;
	bfdo_state_t       state_d;
	logic [ADDR_W-1:0] oldest_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  rem_q;
	logic              out_valid_q;
	logic              status_q;
	logic [7:0]        first_q;
	logic [7:0]        second_q;
	logic              last_q;
	logic [FILL_W-1:0] fill_out_q;

	logic              out_free;
	logic              store_full;
	logic [FILL_W-1:0] need;
	logic              do_write;
	logic              do_short;
	logic              start_read;
	logic              do_sample;
	logic [ADDR_W-1:0] wr_addr;

	assign out_free   = !out_valid_q || !out_stall;
	assign store_full = (fill_q == FILL_W'(BUFFER_BYTES));
	assign need       = FILL_W'(cmd.count) << 1;
	assign wr_addr    = store_full ? oldest_q : (oldest_q + fill_q[ADDR_W-1:0]);

	always_comb begin
		state_d    = state_q;
		do_write   = 1'b0;
		do_short   = 1'b0;
		start_read = 1'b0;
		do_sample  = 1'b0;
		cmd_pop    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_WRITE) begin
						do_write = 1'b1;
						cmd_pop  = 1'b1;
					end else if (fill_q < need) begin
						if (out_free) begin
							do_short = 1'b1;
							cmd_pop  = 1'b1;
						end
					end else begin
						start_read = 1'b1;
						cmd_pop    = 1'b1;
						state_d    = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					do_sample = 1'b1;
					if (rem_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_write) begin
				if (store_full) begin
					oldest_q <= oldest_q + ADDR_W'(1);
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (start_read) begin
				rem_q <= cmd.count;
			end
			if (do_sample) begin
				oldest_q <= oldest_q + ADDR_W'(2);
				fill_q   <= fill_q - FILL_W'(2);
				rem_q    <= rem_q - CNT_W'(1);
			end
			if (do_short || do_sample) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			store[wr_addr] <= cmd.data;
		end
		if (do_sample) begin
			first_q  <= store[oldest_q];
			second_q <= store[oldest_q + ADDR_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (do_short) begin
			status_q   <= STATUS_SHORT;
			last_q     <= 1'b1;
			fill_out_q <= fill_q;
		end else if (do_sample) begin
			status_q   <= STATUS_OK;
			last_q     <= (rem_q == CNT_W'(1));
			fill_out_q <= fill_q - FILL_W'(2);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign first_byte  = (status_q == STATUS_SHORT) ? 8'd0 : first_q;
	assign second_byte = (status_q == STATUS_SHORT) ? 8'd0 : second_q;
	assign last        = last_q;
	assign fill_level  = fill_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BUFFER_BYTES))
		else $error("fill count above store size");

	a_read_covered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (rem_q != '0) && (fill_q >= (FILL_W'(rem_q) << 1)))
		else $error("read in progress without enough held bytes");

	a_sample_fill: assert property (@(posedge clk) disable iff (!arst_n)
		do_sample |=> fill_q == $past(fill_q) - FILL_W'(2))
		else $error("sample did not remove two bytes");

	a_no_pop_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !cmd_pop)
		else $error("command taken while a read is running");

endmodule

### hdl/byte_fifo_drop_oldest_sample_reader_core.sv
// Top level: voice byte FIFO that drops its oldest byte when full, read as samples.
// Writes go via the front register and command queue to the store, one per cycle unless stalled.
// Reads go via the front register, queue and read state; one sample per cycle while not stalled.
// A read of N samples holds the back stage in its read state; a short read gives one short status.
// Reset clears pointers, fill count, queue and valid flags; store contents stay undefined.
module byte_fifo_drop_oldest_sample_reader_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [7:0]                  data_byte,
	input  logic                        frame_is_voice,
	input  logic                        frame_last,
	input  logic [bfdo_pkg::CNT_W-1:0]  sample_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [7:0]                  first_byte,
	output logic [7:0]                  second_byte,
	output logic                        last,
	output logic [bfdo_pkg::FILL_W-1:0] fill_level
);
	import bfdo_pkg::*;

	logic push_valid;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;

	bfdo_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.data_byte      (data_byte),
		.frame_is_voice (frame_is_voice),
		.frame_last     (frame_last),
		.sample_count   (sample_count),
		.push_valid     (push_valid),
		.push_cmd       (push_cmd),
		.q_full         (q_full)
	);

	bfdo_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd)
	);

	bfdo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.last        (last),
		.fill_level  (fill_level)
	);

endmodule
